### hw/rtl/pss_pkg.sv
`default_nettype none
package pss_pkg;

  localparam int unsigned PW      = 10;
  localparam int unsigned MAPW    = 64;
  localparam int unsigned WORDS   = 16;
  localparam int unsigned WW      = 4;
  localparam int unsigned MAXS    = 8;
  localparam int unsigned IXW     = 3;
  localparam int unsigned CNTW    = 4;
  localparam int unsigned GW      = 11;

  localparam logic [GW-1:0]   PIECES_G  = 11'd1024;
  localparam logic [PW-1:0]   WORDS_P   = 10'd16;
  localparam logic [CNTW-1:0] MAX_SEL   = 4'd8;
  localparam logic [GW-1:0]   PC_RESET  = 11'd1024;
  localparam logic            REG_PIECE_COUNT = 1'b0;

  localparam logic [3:0] CMD_SELECT   = 4'd0;
  localparam logic [3:0] CMD_DESELECT = 4'd1;
  localparam logic [3:0] CMD_WINDOW   = 4'd2;
  localparam logic [3:0] CMD_COMPLETE = 4'd3;
  localparam logic [3:0] CMD_RESET    = 4'd4;
  localparam logic [3:0] CMD_GC       = 4'd5;
  localparam logic [3:0] CMD_CHOOSE   = 4'd6;
  localparam logic [3:0] CMD_SET_CRIT = 4'd7;
  localparam logic [3:0] CMD_QUERY    = 4'd8;
  localparam logic [3:0] CMD_PEER     = 4'd9;

  localparam logic [2:0] KIND_RESP   = 3'd0;
  localparam logic [2:0] KIND_INT    = 3'd1;
  localparam logic [2:0] KIND_UNINT  = 3'd2;
  localparam logic [2:0] KIND_IDLE   = 3'd3;
  localparam logic [2:0] KIND_NOTIFY = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_RANGE    = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic [31:0]        id;
    logic [PW-1:0]      first;
    logic [PW-1:0]      last;
    logic [PW-1:0]      offset;
    logic [PW-1:0]      wend;
    logic [PW-1:0]      rstart;
    logic signed [31:0] prio;
  } entry_t;

  typedef struct packed {
    logic           wr_all;
    logic           wr_win;
    logic           wr_off;
    logic [IXW-1:0] idx;
    entry_t         data;
  } tbl_wr_t;

  typedef struct packed {
    logic            pend_wr;
    logic            pend_val;
    logic            crit_wr;
    logic            crit_val;
    logic            peer_wr;
    logic [WW-1:0]   peer_word;
    logic [MAPW-1:0] peer_data;
  } map_op_t;

  typedef struct packed {
    logic pend;
    logic crit;
    logic peer;
  } map_bits_t;

  typedef enum logic [12:0] {
    S_IDLE      = 13'b0000000000001,
    S_INS       = 13'b0000000000010,
    S_FIND      = 13'b0000000000100,
    S_DEL       = 13'b0000000001000,
    S_GC_ADV    = 13'b0000000010000,
    S_GC_TAIL   = 13'b0000000100000,
    S_GC_UNI    = 13'b0000001000000,
    S_CH_UP_ENT = 13'b0000010000000,
    S_CH_UP     = 13'b0000100000000,
    S_CH_DN_ENT = 13'b0001000000000,
    S_CH_DN     = 13'b0010000000000,
    S_CRIT      = 13'b0100000000000,
    S_FIN       = 13'b1000000000000
  } state_t;

endpackage
`default_nettype wire

### hw/rtl/pss_table.sv
`default_nettype none
module pss_table (
  input  wire logic                      clk,
  input  wire pss_pkg::tbl_wr_t          wr,
  input  wire logic [pss_pkg::IXW-1:0]   rd_idx,
  output pss_pkg::entry_t                rd_entry
);

  pss_pkg::entry_t ent_r [pss_pkg::MAXS];

  always_ff @(posedge clk) begin
    if (wr.wr_all) begin
      ent_r[wr.idx] <= wr.data;
    end
    if (wr.wr_win) begin
      ent_r[wr.idx].rstart <= wr.data.rstart;
      ent_r[wr.idx].wend   <= wr.data.wend;
    end
    if (wr.wr_off) begin
      ent_r[wr.idx].offset <= wr.data.offset;
    end
  end

  assign rd_entry = ent_r[rd_idx];

endmodule
`default_nettype wire

### hw/rtl/pss_maps.sv
`default_nettype none
module pss_maps (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic [pss_pkg::PW-1:0]  addr,
  input  wire pss_pkg::map_op_t        op,
  output pss_pkg::map_bits_t           bits
);

  logic [pss_pkg::MAPW-1:0] pend_r [pss_pkg::WORDS];
  logic [pss_pkg::MAPW-1:0] crit_r [pss_pkg::WORDS];
  logic [pss_pkg::MAPW-1:0] peer_r [pss_pkg::WORDS];

  logic [pss_pkg::WW-1:0] wsel;
  logic [5:0]             bsel;

  assign wsel = addr[pss_pkg::PW-1:6];
  assign bsel = addr[5:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int w = 0; w < pss_pkg::WORDS; w++) begin
        pend_r[w] <= '1;
        crit_r[w] <= '0;
        peer_r[w] <= '0;
      end
    end else begin
      if (op.pend_wr) begin
        pend_r[wsel][bsel] <= op.pend_val;
      end
      if (op.crit_wr) begin
        crit_r[wsel][bsel] <= op.crit_val;
      end
      if (op.peer_wr) begin
        peer_r[op.peer_word] <= op.peer_data;
      end
    end
  end

  assign bits = {pend_r[wsel][bsel], crit_r[wsel][bsel], peer_r[wsel][bsel]};

endmodule
`default_nettype wire

### hw/rtl/piece_selection_scheduler_unit.sv
`default_nettype none
// Channel   Handshake              Payload
// in        start / busy           in_cmd .. in_requests_empty
// out       out_valid (strobe)     out_kind .. out_last
// cfg       APB psel/penable       piece_count at byte address 0
//
// One item at a time; busy stays high from accept until the final response.
// GC steps one piece per cycle per selection; choose tests one piece per cycle
// over the windows; set_critical marks one piece per cycle.
// Synchronous active-low reset; events and the response strobe for one cycle each
// and cannot be stalled.
module piece_selection_scheduler_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [3:0]         in_cmd,
  input  wire logic [31:0]        in_sel_id,
  input  wire logic [9:0]         in_range_from,
  input  wire logic [9:0]         in_range_to,
  input  wire logic [9:0]         in_select_to,
  input  wire logic [9:0]         in_read_from,
  input  wire logic signed [31:0] in_priority_req,
  input  wire logic [9:0]         in_piece,
  input  wire logic [10:0]        in_span_width,
  input  wire logic [63:0]        in_peer_bits,
  input  wire logic               in_downloaded_any,
  input  wire logic               in_requests_empty,
  output logic                    out_valid,
  output logic [2:0]              out_kind,
  output logic [31:0]             out_event_id,
  output logic [1:0]              out_status,
  output logic                    out_piece_found,
  output logic [9:0]              out_chosen_piece,
  output logic                    out_is_critical,
  output logic                    out_last,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int unsigned PW  = pss_pkg::PW;
  localparam int unsigned GW  = pss_pkg::GW;
  localparam int unsigned CW  = pss_pkg::CNTW;
  localparam int unsigned IXW = pss_pkg::IXW;

  // configuration
  logic [GW-1:0] pc_r;
  logic [GW-1:0] geo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= pss_pkg::PC_RESET;
    end else if (psel && penable && pwrite && paddr[2] == pss_pkg::REG_PIECE_COUNT) begin
      pc_r <= pwdata[GW-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == pss_pkg::REG_PIECE_COUNT) ? {21'd0, pc_r} : 32'd0;
  assign geo    = (pc_r > pss_pkg::PIECES_G) ? pss_pkg::PIECES_G : pc_r;

  // sequencer state
  pss_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [CW-1:0]   i_r, i_nxt;
  logic [CW-1:0]   gc_i_r, gc_i_nxt;
  logic [GW-1:0]   p_r, p_nxt;
  logic [31:0]     next_id_r, next_id_nxt;
  logic            int_r, int_nxt;
  logic            idle_sent_r, idle_sent_nxt;
  logic            moved_r, moved_nxt;
  logic            gcmode_r, gcmode_nxt;
  logic            fin_int_r, fin_int_nxt;
  logic            fin_unint_r, fin_unint_nxt;
  logic            fin_idle_r, fin_idle_nxt;
  logic [31:0]     rsp_id_r, rsp_id_nxt;
  logic [1:0]      rsp_st_r, rsp_st_nxt;
  logic            rsp_found_r, rsp_found_nxt;
  logic [PW-1:0]   rsp_pick_r, rsp_pick_nxt;
  logic            rsp_crit_r, rsp_crit_nxt;

  // latched item
  logic [3:0]         cmd_r;
  logic [31:0]        sid_r;
  logic [PW-1:0]      rfrom_r, rto_r, sto_r, rdf_r, piece_r;
  logic signed [31:0] prio_r;
  logic [GW-1:0]      span_r;

  // emission
  logic          em_v;
  logic [2:0]    em_kind;
  logic [31:0]   em_id;
  logic [1:0]    em_st;
  logic          em_found;
  logic [PW-1:0] em_pick;
  logic          em_crit;
  logic          em_last;

  // datapath links
  pss_pkg::tbl_wr_t   twr;
  logic [CW-1:0]      rd_sel;
  pss_pkg::entry_t    e;
  pss_pkg::map_op_t   mop;
  pss_pkg::map_bits_t mb;
  logic [PW-1:0]      maddr;
  logic [GW-1:0]      cur;
  logic [GW:0]        crit_addr;
  logic               accept;
  logic               sel_bad;

  pss_table u_table (
    .clk      (clk),
    .wr       (twr),
    .rd_idx   (rd_sel[IXW-1:0]),
    .rd_entry (e)
  );

  pss_maps u_maps (
    .clk   (clk),
    .rst_n (rst_n),
    .addr  (maddr),
    .op    (mop),
    .bits  (mb)
  );

  assign busy      = (state_r != pss_pkg::S_IDLE);
  assign accept    = start && !busy;
  assign cur       = {1'b0, e.first} + {1'b0, e.offset};
  assign crit_addr = {2'b00, piece_r} + {1'b0, p_r};
  assign sel_bad   = (in_range_from > in_range_to) || ({1'b0, in_range_to} >= geo) ||
                     (in_read_from < in_range_from) || (in_read_from > in_select_to) ||
                     (in_select_to > in_range_to);

  always_comb begin
    case (state_r)
      pss_pkg::S_INS, pss_pkg::S_CH_DN_ENT, pss_pkg::S_CH_DN: rd_sel = i_r - 4'd1;
      pss_pkg::S_DEL: rd_sel = i_r + 4'd1;
      default:        rd_sel = i_r;
    endcase
  end

  always_comb begin
    case (state_r)
      pss_pkg::S_GC_ADV, pss_pkg::S_GC_TAIL: maddr = cur[PW-1:0];
      pss_pkg::S_CH_UP, pss_pkg::S_CH_DN:    maddr = p_r[PW-1:0];
      pss_pkg::S_CRIT:                        maddr = crit_addr[PW-1:0];
      default:                                maddr = in_piece;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    i_nxt         = i_r;
    gc_i_nxt      = gc_i_r;
    p_nxt         = p_r;
    next_id_nxt   = next_id_r;
    int_nxt       = int_r;
    idle_sent_nxt = idle_sent_r;
    moved_nxt     = moved_r;
    gcmode_nxt    = gcmode_r;
    fin_int_nxt   = fin_int_r;
    fin_unint_nxt = fin_unint_r;
    fin_idle_nxt  = fin_idle_r;
    rsp_id_nxt    = rsp_id_r;
    rsp_st_nxt    = rsp_st_r;
    rsp_found_nxt = rsp_found_r;
    rsp_pick_nxt  = rsp_pick_r;
    rsp_crit_nxt  = rsp_crit_r;
    twr           = '0;
    twr.idx       = i_r[IXW-1:0];
    twr.data      = e;
    mop           = '0;
    em_v          = 1'b0;
    em_kind       = pss_pkg::KIND_RESP;
    em_id         = 32'd0;
    em_st         = pss_pkg::ST_OK;
    em_found      = 1'b0;
    em_pick       = '0;
    em_crit       = 1'b0;
    em_last       = 1'b0;

    case (state_r)
      pss_pkg::S_IDLE: begin
        if (start) begin
          rsp_id_nxt    = 32'd0;
          rsp_st_nxt    = pss_pkg::ST_OK;
          rsp_found_nxt = 1'b0;
          rsp_pick_nxt  = '0;
          rsp_crit_nxt  = 1'b0;
          fin_int_nxt   = 1'b0;
          fin_unint_nxt = 1'b0;
          fin_idle_nxt  = 1'b0;
          state_nxt     = pss_pkg::S_FIN;
          case (in_cmd)
            pss_pkg::CMD_SELECT: begin
              if (sel_bad) begin
                rsp_st_nxt = pss_pkg::ST_RANGE;
              end else if (cnt_r == pss_pkg::MAX_SEL) begin
                rsp_st_nxt = pss_pkg::ST_FULL;
              end else begin
                i_nxt     = cnt_r;
                state_nxt = pss_pkg::S_INS;
              end
            end
            pss_pkg::CMD_DESELECT, pss_pkg::CMD_WINDOW: begin
              i_nxt     = '0;
              state_nxt = pss_pkg::S_FIND;
            end
            pss_pkg::CMD_COMPLETE, pss_pkg::CMD_RESET: begin
              if ({1'b0, in_piece} >= geo) begin
                rsp_st_nxt = pss_pkg::ST_RANGE;
              end else begin
                mop.pend_wr  = 1'b1;
                mop.pend_val = (in_cmd == pss_pkg::CMD_RESET);
                mop.crit_wr  = (in_cmd == pss_pkg::CMD_RESET);
                mop.crit_val = 1'b0;
              end
            end
            pss_pkg::CMD_GC: begin
              i_nxt     = '0;
              moved_nxt = 1'b0;
              state_nxt = pss_pkg::S_GC_ADV;
            end
            pss_pkg::CMD_CHOOSE: begin
              if (in_downloaded_any) begin
                i_nxt     = '0;
                state_nxt = pss_pkg::S_CH_UP_ENT;
              end else if (in_requests_empty) begin
                i_nxt     = cnt_r;
                state_nxt = pss_pkg::S_CH_DN_ENT;
              end
            end
            pss_pkg::CMD_SET_CRIT: begin
              p_nxt     = '0;
              state_nxt = pss_pkg::S_CRIT;
            end
            pss_pkg::CMD_QUERY: begin
              rsp_crit_nxt = ({1'b0, in_piece} < geo) && mb.crit;
            end
            pss_pkg::CMD_PEER: begin
              if (in_piece >= pss_pkg::WORDS_P) begin
                rsp_st_nxt = pss_pkg::ST_RANGE;
              end else begin
                mop.peer_wr   = 1'b1;
                mop.peer_word = in_piece[pss_pkg::WW-1:0];
                mop.peer_data = in_peer_bits;
              end
            end
            default: rsp_st_nxt = pss_pkg::ST_RANGE;
          endcase
        end
      end

      pss_pkg::S_INS: begin
        // move lower-priority entries up one slot, then drop the new one in
        if (i_r != '0 && e.prio < prio_r) begin
          twr.wr_all = 1'b1;
          i_nxt      = i_r - 4'd1;
        end else begin
          twr.wr_all      = 1'b1;
          twr.data.id     = next_id_r;
          twr.data.first  = rfrom_r;
          twr.data.last   = rto_r;
          twr.data.offset = '0;
          twr.data.wend   = sto_r;
          twr.data.rstart = rdf_r;
          twr.data.prio   = prio_r;
          cnt_nxt         = cnt_r + 4'd1;
          next_id_nxt     = next_id_r + 32'd1;
          idle_sent_nxt   = 1'b0;
          rsp_id_nxt      = next_id_r;
          fin_int_nxt     = !int_r;
          int_nxt         = 1'b1;
          state_nxt       = pss_pkg::S_FIN;
        end
      end

      pss_pkg::S_FIND: begin
        if (i_r < cnt_r) begin
          if (e.id == sid_r) begin
            if (cmd_r == pss_pkg::CMD_DESELECT) begin
              gcmode_nxt = 1'b0;
              state_nxt  = pss_pkg::S_DEL;
            end else begin
              if (rdf_r < e.first || rdf_r > sto_r || sto_r > e.last) begin
                rsp_st_nxt = pss_pkg::ST_RANGE;
              end else begin
                twr.wr_win      = 1'b1;
                twr.data.rstart = rdf_r;
                twr.data.wend   = sto_r;
              end
              state_nxt = pss_pkg::S_FIN;
            end
          end else begin
            i_nxt = i_r + 4'd1;
          end
        end else begin
          rsp_st_nxt = pss_pkg::ST_NOTFOUND;
          state_nxt  = pss_pkg::S_FIN;
        end
      end

      pss_pkg::S_DEL: begin
        if (i_r + 4'd1 < cnt_r) begin
          twr.wr_all = 1'b1;
          i_nxt      = i_r + 4'd1;
        end else begin
          cnt_nxt = cnt_r - 4'd1;
          if (gcmode_r) begin
            state_nxt = pss_pkg::S_GC_UNI;
          end else begin
            if (cnt_r == 4'd1) begin
              fin_unint_nxt = int_r;
              int_nxt       = 1'b0;
              fin_idle_nxt  = !idle_sent_r;
              idle_sent_nxt = 1'b1;
            end
            state_nxt = pss_pkg::S_FIN;
          end
        end
      end

      pss_pkg::S_GC_UNI: begin
        if (cnt_r == '0 && int_r) begin
          em_v    = 1'b1;
          em_kind = pss_pkg::KIND_UNINT;
          int_nxt = 1'b0;
        end
        // resume at the slot the removed entry left
        i_nxt     = gc_i_r;
        moved_nxt = 1'b0;
        state_nxt = pss_pkg::S_GC_ADV;
      end

      pss_pkg::S_GC_ADV: begin
        if (i_r >= cnt_r) begin
          if (cnt_r == '0 && !idle_sent_r) begin
            fin_idle_nxt  = 1'b1;
            idle_sent_nxt = 1'b1;
          end
          state_nxt = pss_pkg::S_FIN;
        end else if (cur < {1'b0, e.last} && !mb.pend) begin
          twr.wr_off      = 1'b1;
          twr.data.offset = e.offset + 10'd1;
          moved_nxt       = 1'b1;
        end else begin
          if (moved_r) begin
            em_v    = 1'b1;
            em_kind = pss_pkg::KIND_NOTIFY;
            em_id   = e.id;
          end
          moved_nxt = 1'b0;
          state_nxt = pss_pkg::S_GC_TAIL;
        end
      end

      pss_pkg::S_GC_TAIL: begin
        if (cur == {1'b0, e.last} && !mb.pend) begin
          em_v       = 1'b1;
          em_kind    = pss_pkg::KIND_NOTIFY;
          em_id      = e.id;
          gcmode_nxt = 1'b1;
          gc_i_nxt   = i_r;
          state_nxt  = pss_pkg::S_DEL;
        end else begin
          i_nxt     = i_r + 4'd1;
          state_nxt = pss_pkg::S_GC_ADV;
        end
      end

      pss_pkg::S_CH_UP_ENT: begin
        if (i_r >= cnt_r) begin
          state_nxt = pss_pkg::S_FIN;
        end else begin
          p_nxt     = cur;
          state_nxt = pss_pkg::S_CH_UP;
        end
      end

      pss_pkg::S_CH_UP: begin
        if (p_r > {1'b0, e.wend}) begin
          i_nxt     = i_r + 4'd1;
          state_nxt = pss_pkg::S_CH_UP_ENT;
        end else if (mb.peer && mb.pend) begin
          rsp_found_nxt = 1'b1;
          rsp_pick_nxt  = p_r[PW-1:0];
          state_nxt     = pss_pkg::S_FIN;
        end else begin
          p_nxt = p_r + 11'd1;
        end
      end

      pss_pkg::S_CH_DN_ENT: begin
        if (i_r == '0) begin
          state_nxt = pss_pkg::S_FIN;
        end else if ({1'b0, e.wend} < cur) begin
          i_nxt = i_r - 4'd1;
        end else begin
          p_nxt     = {1'b0, e.wend};
          state_nxt = pss_pkg::S_CH_DN;
        end
      end

      pss_pkg::S_CH_DN: begin
        if (mb.peer && mb.pend) begin
          rsp_found_nxt = 1'b1;
          rsp_pick_nxt  = p_r[PW-1:0];
          state_nxt     = pss_pkg::S_FIN;
        end else if (p_r == cur) begin
          i_nxt     = i_r - 4'd1;
          state_nxt = pss_pkg::S_CH_DN_ENT;
        end else begin
          p_nxt = p_r - 11'd1;
        end
      end

      pss_pkg::S_CRIT: begin
        if (p_r < span_r && crit_addr < {1'b0, geo}) begin
          mop.crit_wr  = 1'b1;
          mop.crit_val = 1'b1;
          p_nxt        = p_r + 11'd1;
        end else begin
          state_nxt = pss_pkg::S_FIN;
        end
      end

      pss_pkg::S_FIN: begin
        em_v = 1'b1;
        if (fin_int_r) begin
          em_kind     = pss_pkg::KIND_INT;
          fin_int_nxt = 1'b0;
        end else if (fin_unint_r) begin
          em_kind       = pss_pkg::KIND_UNINT;
          fin_unint_nxt = 1'b0;
        end else if (fin_idle_r) begin
          em_kind      = pss_pkg::KIND_IDLE;
          fin_idle_nxt = 1'b0;
        end else begin
          em_kind   = pss_pkg::KIND_RESP;
          em_id     = rsp_id_r;
          em_st     = rsp_st_r;
          em_found  = rsp_found_r;
          em_pick   = rsp_pick_r;
          em_crit   = rsp_crit_r;
          em_last   = 1'b1;
          state_nxt = pss_pkg::S_IDLE;
        end
      end

      default: state_nxt = pss_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pss_pkg::S_IDLE;
      cnt_r       <= '0;
      i_r         <= '0;
      gc_i_r      <= '0;
      p_r         <= '0;
      next_id_r   <= '0;
      int_r       <= 1'b0;
      idle_sent_r <= 1'b0;
      moved_r     <= 1'b0;
      gcmode_r    <= 1'b0;
      fin_int_r   <= 1'b0;
      fin_unint_r <= 1'b0;
      fin_idle_r  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      i_r         <= i_nxt;
      gc_i_r      <= gc_i_nxt;
      p_r         <= p_nxt;
      next_id_r   <= next_id_nxt;
      int_r       <= int_nxt;
      idle_sent_r <= idle_sent_nxt;
      moved_r     <= moved_nxt;
      gcmode_r    <= gcmode_nxt;
      fin_int_r   <= fin_int_nxt;
      fin_unint_r <= fin_unint_nxt;
      fin_idle_r  <= fin_idle_nxt;
      out_valid   <= em_v;
    end
  end

  always_ff @(posedge clk) begin
    rsp_id_r         <= rsp_id_nxt;
    rsp_st_r         <= rsp_st_nxt;
    rsp_found_r      <= rsp_found_nxt;
    rsp_pick_r       <= rsp_pick_nxt;
    rsp_crit_r       <= rsp_crit_nxt;
    out_kind         <= em_kind;
    out_event_id     <= em_id;
    out_status       <= em_st;
    out_piece_found  <= em_found;
    out_chosen_piece <= em_pick;
    out_is_critical  <= em_crit;
    out_last         <= em_last;
    if (accept) begin
      cmd_r   <= in_cmd;
      sid_r   <= in_sel_id;
      rfrom_r <= in_range_from;
      rto_r   <= in_range_to;
      sto_r   <= in_select_to;
      rdf_r   <= in_read_from;
      prio_r  <= in_priority_req;
      piece_r <= in_piece;
      span_r  <= in_span_width;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/pss_checker.sv
`default_nettype none
module pss_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       out_valid,
  input wire logic [2:0] out_kind,
  input wire logic       out_last
);

  // an accepted item raises busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> !busy)
    else $error("busy after final response");

  a_event_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy)
    else $error("event outside an item");

  a_kind_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_kind == pss_pkg::KIND_RESP) == out_last))
    else $error("response kind and last disagree");

  a_no_idle_out: assert property (@(posedge clk) disable iff (!rst_n)
    !busy && !$past(busy) |-> !out_valid)
    else $error("result while idle");

endmodule

bind piece_selection_scheduler_unit pss_checker u_pss_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_kind  (out_kind),
  .out_last  (out_last)
);
`default_nettype wire

### dv/tb_piece_selection_scheduler_unit.sv
module tb_piece_selection_scheduler_unit;

  typedef struct {
    logic [3:0]         cmd;
    logic [31:0]        sel_id;
    logic [9:0]         rfrom;
    logic [9:0]         rto;
    logic [9:0]         sto;
    logic [9:0]         rdf;
    logic signed [31:0] prio;
    logic [9:0]         piece;
    logic [10:0]        span;
    logic [63:0]        bits;
    logic               dl;
    logic               rqe;
  } cmd_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] id;
    logic [1:0]  status;
    logic        found;
    logic [9:0]  chosen;
    logic        crit;
    logic        last;
  } resp_t;

  typedef struct {
    logic [31:0]        id;
    int                 first;
    int                 last;
    int                 offset;
    int                 wend;
    int                 rstart;
    logic signed [31:0] prio;
  } sel_t;

  class picker_scoreboard;
    resp_t     pending_resp[$];
    bit        pend_map[1024];
    bit        crit_map[1024];
    bit [63:0] peer_map[16];
    sel_t      tbl[8];
    int        count;
    bit [31:0] next_id;
    bit        interested;
    bit        idle_sent;
    int        piece_count;
    int        n_items, n_results, n_chosen, n_added;

    function new();
      foreach (pend_map[i]) pend_map[i] = 1'b1;
      foreach (crit_map[i]) crit_map[i] = 1'b0;
      foreach (peer_map[i]) peer_map[i] = '0;
      count = 0;
      next_id = 0;
      interested = 0;
      idle_sent = 0;
      piece_count = 1024;
    endfunction

    function void push(logic [2:0] kind, logic [31:0] id, logic [1:0] st, logic found,
                       logic [9:0] chosen, logic crit, logic last);
      resp_t r;
      r.kind = kind; r.id = id; r.status = st; r.found = found;
      r.chosen = chosen; r.crit = crit; r.last = last;
      pending_resp = {pending_resp, r};
    endfunction

    function void interest(bit want);
      if (interested == want) return;
      interested = want;
      push(want ? pss_pkg::KIND_INT : pss_pkg::KIND_UNINT, 0, pss_pkg::ST_OK, 0, 0, 0, 0);
    endfunction

    function int find(logic [31:0] id);
      for (int i = 0; i < count; i++) if (tbl[i].id == id) return i;
      return -1;
    endfunction

    function void drop(int k);
      for (int i = k; i + 1 < count; i++) tbl[i] = tbl[i + 1];
      if (count > 0) count--;
    endfunction

    function bit held(int p);
      return p < 1024 && peer_map[p / 64][p % 64] && pend_map[p];
    endfunction

    // Work out every result of one accepted item.
    function void note(cmd_item_t it);
      int g, k, pos, i, p, lo, old;
      bit found;
      int pick;
      g = piece_count > 1024 ? 1024 : piece_count;
      n_items++;
      case (it.cmd)
        pss_pkg::CMD_SELECT: begin
          if (it.rfrom > it.rto || it.rto >= g || it.rdf < it.rfrom || it.rdf > it.sto ||
              it.sto > it.rto) begin
            push(pss_pkg::KIND_RESP, 0, pss_pkg::ST_RANGE, 0, 0, 0, 1);
          end else if (count >= 8) begin
            push(pss_pkg::KIND_RESP, 0, pss_pkg::ST_FULL, 0, 0, 0, 1);
          end else begin
            pos = 0;
            while (pos < count && tbl[pos].prio >= it.prio) pos++;
            for (i = count; i > pos; i--) tbl[i] = tbl[i - 1];
            tbl[pos].id = next_id; tbl[pos].first = it.rfrom; tbl[pos].last = it.rto;
            tbl[pos].offset = 0; tbl[pos].wend = it.sto; tbl[pos].rstart = it.rdf;
            tbl[pos].prio = it.prio;
            count++;
            n_added++;
            idle_sent = 0;
            interest(1);
            push(pss_pkg::KIND_RESP, next_id, pss_pkg::ST_OK, 0, 0, 0, 1);
            next_id++;
          end
        end
        pss_pkg::CMD_DESELECT: begin
          k = find(it.sel_id);
          if (k < 0) begin
            push(pss_pkg::KIND_RESP, 0, pss_pkg::ST_NOTFOUND, 0, 0, 0, 1);
          end else begin
            drop(k);
            if (count == 0) begin
              interest(0);
              if (!idle_sent) begin
                push(pss_pkg::KIND_IDLE, 0, pss_pkg::ST_OK, 0, 0, 0, 0);
                idle_sent = 1;
              end
            end
            push(pss_pkg::KIND_RESP, 0, pss_pkg::ST_OK, 0, 0, 0, 1);
          end
        end
        pss_pkg::CMD_WINDOW: begin
          k = find(it.sel_id);
          if (k < 0) begin
            push(pss_pkg::KIND_RESP, 0, pss_pkg::ST_NOTFOUND, 0, 0, 0, 1);
          end else if (it.rdf < tbl[k].first || it.rdf > it.sto || it.sto > tbl[k].last) begin
            push(pss_pkg::KIND_RESP, 0, pss_pkg::ST_RANGE, 0, 0, 0, 1);
          end else begin
            tbl[k].rstart = it.rdf;
            tbl[k].wend = it.sto;
            push(pss_pkg::KIND_RESP, 0, pss_pkg::ST_OK, 0, 0, 0, 1);
          end
        end
        pss_pkg::CMD_COMPLETE, pss_pkg::CMD_RESET: begin
          if (it.piece >= g) begin
            push(pss_pkg::KIND_RESP, 0, pss_pkg::ST_RANGE, 0, 0, 0, 1);
          end else begin
            if (it.cmd == pss_pkg::CMD_COMPLETE) begin
              pend_map[it.piece] = 0;
            end else begin
              pend_map[it.piece] = 1;
              crit_map[it.piece] = 0;
            end
            push(pss_pkg::KIND_RESP, 0, pss_pkg::ST_OK, 0, 0, 0, 1);
          end
        end
        pss_pkg::CMD_GC: begin
          i = 0;
          while (i < count) begin
            old = tbl[i].offset;
            while (tbl[i].first + tbl[i].offset < tbl[i].last &&
                   !pend_map[tbl[i].first + tbl[i].offset])
              tbl[i].offset++;
            if (old != tbl[i].offset)
              push(pss_pkg::KIND_NOTIFY, tbl[i].id, pss_pkg::ST_OK, 0, 0, 0, 0);
            p = tbl[i].first + tbl[i].offset;
            if (p == tbl[i].last && !pend_map[p]) begin
              push(pss_pkg::KIND_NOTIFY, tbl[i].id, pss_pkg::ST_OK, 0, 0, 0, 0);
              drop(i);
              interest(count != 0);
              continue;
            end
            i++;
          end
          if (count == 0 && !idle_sent) begin
            push(pss_pkg::KIND_IDLE, 0, pss_pkg::ST_OK, 0, 0, 0, 0);
            idle_sent = 1;
          end
          push(pss_pkg::KIND_RESP, 0, pss_pkg::ST_OK, 0, 0, 0, 1);
        end
        pss_pkg::CMD_CHOOSE: begin
          found = 0;
          pick = 0;
          if (!it.dl) begin
            // nothing downloaded yet: only with no requests outstanding, lowest priority first, window scanned downward
            if (it.rqe) begin
              for (i = count; i > 0 && !found; i--) begin
                lo = tbl[i - 1].first + tbl[i - 1].offset;
                p = tbl[i - 1].wend + 1;
                while (p > lo) begin
                  p--;
                  if (held(p)) begin
                    found = 1;
                    pick = p;
                    break;
                  end
                end
              end
            end
          end else begin
            for (i = 0; i < count && !found; i++)
              for (p = tbl[i].first + tbl[i].offset; p <= tbl[i].wend; p++)
                if (held(p)) begin
                  found = 1;
                  pick = p;
                  break;
                end
          end
          if (found) n_chosen++;
          push(pss_pkg::KIND_RESP, 0, pss_pkg::ST_OK, found, 10'(pick), 0, 1);
        end
        pss_pkg::CMD_SET_CRIT: begin
          for (i = 0; i < it.span && it.piece + i < g; i++) crit_map[it.piece + i] = 1;
          push(pss_pkg::KIND_RESP, 0, pss_pkg::ST_OK, 0, 0, 0, 1);
        end
        pss_pkg::CMD_QUERY: begin
          push(pss_pkg::KIND_RESP, 0, pss_pkg::ST_OK, 0, 0,
               it.piece < g && crit_map[it.piece], 1);
        end
        pss_pkg::CMD_PEER: begin
          if (it.piece >= 16) begin
            push(pss_pkg::KIND_RESP, 0, pss_pkg::ST_RANGE, 0, 0, 0, 1);
          end else begin
            peer_map[it.piece] = it.bits;
            push(pss_pkg::KIND_RESP, 0, pss_pkg::ST_OK, 0, 0, 0, 1);
          end
        end
        default: push(pss_pkg::KIND_RESP, 0, pss_pkg::ST_RANGE, 0, 0, 0, 1);
      endcase
    endfunction

    // Compare one result with the oldest expectation; empty string on a match.
    function string check(resp_t got);
      resp_t e;
      n_results++;
      if (pending_resp.size() == 0)
        return $sformatf("unexpected result kind=%0d id=%0h", got.kind, got.id);
      e = pending_resp.pop_front();
      if (got !== e)
        return {$sformatf("result %0d: got kind=%0d id=%0h st=%0d f=%0d p=%0d c=%0d l=%0d",
                          n_results, got.kind, got.id, got.status, got.found, got.chosen,
                          got.crit, got.last),
                $sformatf(", want kind=%0d id=%0h st=%0d f=%0d p=%0d c=%0d l=%0d",
                          e.kind, e.id, e.status, e.found, e.chosen, e.crit, e.last)};
      return "";
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic out_valid, out_piece_found, out_is_critical, out_last, pready;
  logic [2:0] out_kind;
  logic [31:0] out_event_id, prdata;
  logic [1:0] out_status;
  logic [9:0] out_chosen_piece;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = 0;
  logic [31:0] pwdata = 0;
  cmd_item_t cur;

  picker_scoreboard sb = new();
  int errors = 0;
  int cycles = 0;
  bit quiet = 0;

  piece_selection_scheduler_unit u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(cur.cmd), .in_sel_id(cur.sel_id), .in_range_from(cur.rfrom),
    .in_range_to(cur.rto), .in_select_to(cur.sto), .in_read_from(cur.rdf),
    .in_priority_req(cur.prio), .in_piece(cur.piece), .in_span_width(cur.span),
    .in_peer_bits(cur.bits), .in_downloaded_any(cur.dl), .in_requests_empty(cur.rqe),
    .out_valid(out_valid), .out_kind(out_kind), .out_event_id(out_event_id),
    .out_status(out_status), .out_piece_found(out_piece_found),
    .out_chosen_piece(out_chosen_piece), .out_is_critical(out_is_critical),
    .out_last(out_last), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  task automatic report(string msg);
    $display("MISMATCH: %s", msg);
    errors++;
  endtask

  always @(posedge clk) begin
    resp_t r;
    string msg;
    cycles++;
    if (cycles > 20000000) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end else if (rst_n) begin
      if (start && !busy) sb.note(cur);
      if (out_valid) begin
        r.kind = out_kind; r.id = out_event_id; r.status = out_status;
        r.found = out_piece_found; r.chosen = out_chosen_piece;
        r.crit = out_is_critical; r.last = out_last;
        msg = sb.check(r);
        if (msg != "") report(msg);
      end
    end
  end

  function automatic cmd_item_t blank(logic [3:0] cmd);
    cmd_item_t it;
    it = '{cmd: cmd, sel_id: 0, rfrom: 0, rto: 0, sto: 0, rdf: 0, prio: 0, piece: 0,
           span: 0, bits: 0, dl: 0, rqe: 0};
    return it;
  endfunction

  function automatic cmd_item_t sel_item(int from, int to, int sto, int rdf, int prio);
    cmd_item_t it;
    it = blank(pss_pkg::CMD_SELECT);
    it.rfrom = 10'(from); it.rto = 10'(to); it.sto = 10'(sto); it.rdf = 10'(rdf);
    it.prio = prio;
    return it;
  endfunction

  // Present one item at the falling edge and hold it until accepted.
  task automatic send(cmd_item_t it);
    if (!quiet && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 18)) @(negedge clk);
    cur = it;
    start = 1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    start = 0;
  endtask

  task automatic drain();
    while (sb.pending_resp.size() != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_piece_count(int value);
    drain();
    psel = 1; pwrite = 1; paddr = {pss_pkg::REG_PIECE_COUNT, 2'b00}; pwdata = 32'(value);
    @(negedge clk);
    penable = 1;
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
    sb.piece_count = value & 32'h7ff;
  endtask

  function automatic cmd_item_t random_item();
    cmd_item_t it;
    int g, r, from, len, k;
    g = sb.piece_count > 1024 ? 1024 : sb.piece_count;
    it = blank(4'($urandom_range(0, 9)));
    it.sel_id = $urandom(); it.rfrom = 10'($urandom()); it.rto = 10'($urandom());
    it.sto = 10'($urandom()); it.rdf = 10'($urandom()); it.prio = $urandom();
    it.piece = 10'($urandom()); it.span = 11'($urandom_range(0, 1024));
    it.bits = {$urandom(), $urandom()};
    it.dl = 1'($urandom_range(0, 1)); it.rqe = 1'($urandom_range(0, 1));
    r = $urandom_range(0, 99);
    if (r < 8) return it;  // noise
    if (g == 0) return it;
    from = $urandom_range(0, g - 1);
    len = ($urandom_range(0, 19) == 0) ? $urandom_range(0, g - 1) : $urandom_range(0, 24);
    if (from + len > g - 1) len = g - 1 - from;
    k = sb.count > 0 ? $urandom_range(0, sb.count - 1) : 0;
    if (it.cmd == pss_pkg::CMD_SELECT) begin
      it.rfrom = 10'(from); it.rto = 10'(from + len);
      it.rdf = 10'(from + $urandom_range(0, len));
      it.sto = 10'(it.rdf + $urandom_range(0, from + len - it.rdf));
      if ($urandom_range(0, 1)) it.prio = 32'($urandom_range(0, 3) << 16);
    end else if ((it.cmd == pss_pkg::CMD_DESELECT || it.cmd == pss_pkg::CMD_WINDOW) &&
                 sb.count > 0 && $urandom_range(0, 4) != 0) begin
      it.sel_id = sb.tbl[k].id;
      it.rdf = 10'(sb.tbl[k].first + $urandom_range(0, sb.tbl[k].last - sb.tbl[k].first));
      it.sto = 10'(it.rdf + $urandom_range(0, sb.tbl[k].last - it.rdf));
      if (it.cmd == pss_pkg::CMD_DESELECT && $urandom_range(0, 1))
        it = blank(pss_pkg::CMD_GC);
    end else if ((it.cmd == pss_pkg::CMD_COMPLETE || it.cmd == pss_pkg::CMD_RESET ||
                  it.cmd == pss_pkg::CMD_PEER) && sb.count > 0 &&
                 $urandom_range(0, 3) != 0) begin
      it.piece = 10'(sb.tbl[k].first + $urandom_range(0, sb.tbl[k].last - sb.tbl[k].first));
      if (it.cmd == pss_pkg::CMD_RESET && $urandom_range(0, 2) != 0)
        it.cmd = pss_pkg::CMD_COMPLETE;
      if (it.cmd == pss_pkg::CMD_PEER) it.piece = it.piece / 64;
    end else if (it.cmd == pss_pkg::CMD_SET_CRIT && $urandom_range(0, 3) != 0) begin
      it.span = 11'($urandom_range(0, 40));
    end
    return it;
  endfunction

  initial begin
    cmd_item_t it;
    int pcs[6] = '{1024, 2047, 137, 0, 1, 1024};
    cur = blank(pss_pkg::CMD_QUERY);
    repeat (9) @(negedge clk);
    rst_n = 1;
    @(negedge clk);
    write_piece_count(1024);

    // directed: select checks, full table, lookups, maps and both choose orders
    send(sel_item(5, 3, 5, 5, 0));
    send(sel_item(0, 1023, 1023, 0, 32'h8000_0000));
    send(sel_item(10, 20, 15, 9, 0));
    send(sel_item(10, 20, 15, 16, 0));
    send(sel_item(10, 20, 21, 12, 0));
    for (int i = 0; i < 7; i++)
      send(sel_item(i * 8, i * 8 + 7, i * 8 + 7, i * 8, i < 4 ? 0 : 32'h7fff_ffff));
    send(sel_item(100, 100, 100, 100, 0));
    it = blank(pss_pkg::CMD_DESELECT); it.sel_id = 32'hffff_ffff; send(it);
    it = blank(pss_pkg::CMD_WINDOW); it.sel_id = 2; it.rdf = 10; it.sto = 5; send(it);
    it = blank(pss_pkg::CMD_WINDOW); it.sel_id = 2; it.rdf = 9; it.sto = 12; send(it);
    it = blank(pss_pkg::CMD_PEER); it.piece = 0; it.bits = '1; send(it);
    it = blank(pss_pkg::CMD_PEER); it.piece = 15; it.bits = 64'h8000_0000_0000_0001;
    send(it);
    it = blank(pss_pkg::CMD_PEER); it.piece = 1023; send(it);
    it = blank(pss_pkg::CMD_COMPLETE); it.piece = 8; send(it);
    it = blank(pss_pkg::CMD_CHOOSE); it.dl = 1; send(it);
    it = blank(pss_pkg::CMD_CHOOSE); it.rqe = 1; send(it);
    it = blank(pss_pkg::CMD_CHOOSE); send(it);
    it = blank(pss_pkg::CMD_SET_CRIT); it.piece = 1000; it.span = 1024; send(it);
    it = blank(pss_pkg::CMD_QUERY); it.piece = 1023; send(it);
    it = blank(pss_pkg::CMD_RESET); it.piece = 1023; send(it);
    it = blank(pss_pkg::CMD_GC); send(it);
    it = blank(4'hf); send(it);

    // random phases across piece counts, extremes included
    foreach (pcs[ph]) begin
      write_piece_count(pcs[ph]);
      for (int n = 0; n < 42; n++) begin
        if (ph == 2 && n == 20) drain();
        if (ph == 5 && n == 30) quiet = 1;
        send(random_item());
      end
    end
    drain();
    $display("covered %0d items, %0d results, %0d selections added, %0d pieces chosen",
             sb.n_items, sb.n_results, sb.n_added, sb.n_chosen);
    $display("piece counts 0, 1, 137, 1024 and 2047 were used");
    if (errors == 0 && sb.pending_resp.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
